// File: src/torus_knot_trajectory_defines.svh
// Assertion macros used by the torus knot trajectory top level
`ifndef TORUS_KNOT_TRAJECTORY_DEFINES_SVH
`define TORUS_KNOT_TRAJECTORY_DEFINES_SVH

// Implication in the same cycle, checked outside reset
`define TKT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle, checked outside reset
`define TKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tkt_pkg.sv
// Shared constants, types and tables for the torus knot trajectory block
package tkt_pkg;

   // Sample format and CORDIC length
   localparam int SAMPLE_BITS   = 16;
   localparam int CORDIC_STAGES = 16;

   // Derived widths
   localparam int FACTOR_BITS = 16;
   localparam int TURN_BITS   = SAMPLE_BITS + 8;
   localparam int PROD_BITS   = FACTOR_BITS + SAMPLE_BITS;
   localparam int ANGLE_BITS  = 32;
   localparam int CORDIC_W    = 32;
   localparam int IDX_BITS    = 5;
   localparam int TRIG_BITS   = 16;
   localparam int RAD_BITS    = 17;
   localparam int MUL_BITS    = 33;
   localparam int POS_XY_BITS = 17;
   localparam int POS_Z_BITS  = 16;

   // Port widths
   localparam int REQ_DATA_BITS   = 16;
   localparam int RSP_DATA_BITS   = 56;
   localparam int CSR_INDEX_BITS  = 8;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FACTOR_A = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FACTOR_B = 8'd1;
   localparam logic [FACTOR_BITS-1:0]    FACTOR_A_RESET = 16'd768;
   localparam logic [FACTOR_BITS-1:0]    FACTOR_B_RESET = 16'd1792;

   // CORDIC start vector: gain times 2^30
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032875;

   // Quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // Data carried along a CORDIC chain
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic [1:0]                 quad;
   } cordic_data_type;

   // Arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [ANGLE_BITS-1:0] atan_turn(input logic [IDX_BITS-1:0] idx);
      logic [ANGLE_BITS-1:0] res;
      case (idx)
         5'd0:    res = 32'h20000000;
         5'd1:    res = 32'h12E4051D;
         5'd2:    res = 32'h09FB385B;
         5'd3:    res = 32'h051111D4;
         5'd4:    res = 32'h028B0D43;
         5'd5:    res = 32'h0145D7E1;
         5'd6:    res = 32'h00A2F61E;
         5'd7:    res = 32'h00517C55;
         5'd8:    res = 32'h0028BE53;
         5'd9:    res = 32'h00145F2E;
         5'd10:   res = 32'h000A2F98;
         5'd11:   res = 32'h000517CC;
         5'd12:   res = 32'h00028BE6;
         5'd13:   res = 32'h000145F3;
         5'd14:   res = 32'h0000A2F9;
         5'd15:   res = 32'h0000517C;
         5'd16:   res = 32'h000028BE;
         5'd17:   res = 32'h0000145F;
         5'd18:   res = 32'h00000A2F;
         5'd19:   res = 32'h00000517;
         5'd20:   res = 32'h0000028B;
         5'd21:   res = 32'h00000145;
         5'd22:   res = 32'h000000A2;
         5'd23:   res = 32'h00000051;
         default: res = 32'h00000000;
      endcase
      return res;
   endfunction

endpackage

// File: src/tkt_phase.sv
// Phase product, turn alignment and quadrant split feeding one CORDIC chain
module tkt_phase (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               valid_i,
   input  logic [tkt_pkg::SAMPLE_BITS-1:0]    sample,
   input  logic [tkt_pkg::FACTOR_BITS-1:0]    factor,
   output logic                               valid_o,
   output tkt_pkg::cordic_data_type           data_o
);
   import tkt_pkg::*;

   logic                           prod_valid_ff;
   logic signed [PROD_BITS-1:0]    prod_ff;
   logic signed [PROD_BITS-1:0]    prod_in;
   logic [ANGLE_BITS-1:0]          angle;
   logic [ANGLE_BITS-1:0]          angle_off;
   logic [1:0]                     quad;
   logic                           data_valid_ff;
   cordic_data_type                data_ff;
   cordic_data_type                data_in;

   // Factor times sample: half-turns with SAMPLE_BITS+7 fraction bits
   assign prod_in = PROD_BITS'($signed(factor)) * PROD_BITS'($signed(sample));

   // Low TURN_BITS bits are the angle in turns; line it up to 32 bits
   generate
      if (TURN_BITS >= ANGLE_BITS) begin : g_align_down
         assign angle = prod_ff[TURN_BITS-1 -: ANGLE_BITS];
      end else begin : g_align_up
         assign angle = {prod_ff[TURN_BITS-1:0], {(ANGLE_BITS-TURN_BITS){1'b0}}};
      end
   endgenerate

   // Quadrant from angle plus an eighth turn, residual within an eighth turn
   always_comb begin
      angle_off    = angle + 32'h20000000;
      quad         = angle_off[ANGLE_BITS-1 -: 2];
      data_in.x    = CORDIC_X0;
      data_in.y    = '0;
      data_in.z    = $signed({angle[ANGLE_BITS-1 -: 2] - quad, angle[ANGLE_BITS-3:0]});
      data_in.quad = quad;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         data_valid_ff <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= valid_i;
         data_valid_ff <= prod_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         data_ff <= data_in;
      end
   end

   assign valid_o = data_valid_ff;
   assign data_o  = data_ff;

endmodule

// File: src/tkt_cell.sv
// One CORDIC rotation cell: a micro-rotation by the arctangent of 2^-i
module tkt_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [tkt_pkg::IDX_BITS-1:0]   stage_idx,
   input  logic                           valid_i,
   input  tkt_pkg::cordic_data_type       data_i,
   output logic                           valid_o,
   output tkt_pkg::cordic_data_type       data_o
);
   import tkt_pkg::*;

   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;
   logic signed [CORDIC_W-1:0] ang;
   logic                       valid_ff;
   cordic_data_type            data_ff;
   cordic_data_type            data_in;

   // Rotate towards zero residual; zero counts as positive
   always_comb begin
      dx      = $signed(data_i.y) >>> stage_idx;
      dy      = $signed(data_i.x) >>> stage_idx;
      ang     = $signed(atan_turn(stage_idx));
      data_in = data_i;
      if (!data_i.z[CORDIC_W-1]) begin
         data_in.x = $signed(data_i.x) - dx;
         data_in.y = $signed(data_i.y) + dy;
         data_in.z = $signed(data_i.z) - ang;
      end else begin
         data_in.x = $signed(data_i.x) + dx;
         data_in.y = $signed(data_i.y) - dy;
         data_in.z = $signed(data_i.z) + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

// File: src/tkt_post.sv
// Quadrant fold-back, rounding, radius scaling and output register
module tkt_post (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   valid_i,
   input  tkt_pkg::cordic_data_type               cord_a,
   input  tkt_pkg::cordic_data_type               cord_b,
   output logic                                   valid_o,
   output logic signed [tkt_pkg::POS_XY_BITS-1:0] pos_x,
   output logic signed [tkt_pkg::POS_XY_BITS-1:0] pos_y,
   output logic signed [tkt_pkg::POS_Z_BITS-1:0]  pos_z
);
   import tkt_pkg::*;

   // Round 30 to 14 fraction bits and clamp to plus minus one
   function automatic logic signed [TRIG_BITS-1:0] round14(input logic signed [CORDIC_W:0] v);
      logic signed [CORDIC_W:0] t;
      logic signed [TRIG_BITS-1:0] res;
      t = (v + 33'sd32768) >>> 16;
      if (t > 33'sd16384) begin
         res = 16'sd16384;
      end else if (t < -33'sd16384) begin
         res = -16'sd16384;
      end else begin
         res = TRIG_BITS'(t);
      end
      return res;
   endfunction

   // Rotate back by the quadrant; result is {sin, cos}
   function automatic logic [2*TRIG_BITS-1:0] fold(input cordic_data_type d);
      logic signed [CORDIC_W:0] xe;
      logic signed [CORDIC_W:0] ye;
      logic signed [CORDIC_W:0] c;
      logic signed [CORDIC_W:0] s;
      xe = $signed({d.x[CORDIC_W-1], d.x});
      ye = $signed({d.y[CORDIC_W-1], d.y});
      case (d.quad)
         QUAD_0: begin c = xe;  s = ye;  end
         QUAD_1: begin c = -ye; s = xe;  end
         QUAD_2: begin c = -xe; s = -ye; end
         QUAD_3: begin c = ye;  s = -xe; end
         default: begin c = xe; s = ye; end
      endcase
      return {round14(s), round14(c)};
   endfunction

   // Round 14 fraction bits off the product and clamp to plus minus three
   function automatic logic signed [POS_XY_BITS-1:0] scale(input logic signed [MUL_BITS-1:0] p);
      logic signed [MUL_BITS-1:0] t;
      logic signed [POS_XY_BITS-1:0] res;
      t = (p + 33'sd8192) >>> 14;
      if (t > 33'sd49152) begin
         res = 17'sd49152;
      end else if (t < -33'sd49152) begin
         res = -17'sd49152;
      end else begin
         res = POS_XY_BITS'(t);
      end
      return res;
   endfunction

   logic [2*TRIG_BITS-1:0]        trig_a;
   logic [2*TRIG_BITS-1:0]        trig_b;
   logic                          trig_valid_ff;
   logic signed [TRIG_BITS-1:0]   cos_a_ff, cos_a_in;
   logic signed [TRIG_BITS-1:0]   sin_a_ff, sin_a_in;
   logic signed [TRIG_BITS-1:0]   sin_b_ff, sin_b_in;
   logic signed [RAD_BITS-1:0]    rad_ff, rad_in;
   logic                          mul_valid_ff;
   logic signed [MUL_BITS-1:0]    mul_x_ff, mul_x_in;
   logic signed [MUL_BITS-1:0]    mul_y_ff, mul_y_in;
   logic signed [TRIG_BITS-1:0]   mul_z_ff;
   logic                          out_valid_ff;
   logic signed [POS_XY_BITS-1:0] pos_x_ff, pos_x_in;
   logic signed [POS_XY_BITS-1:0] pos_y_ff, pos_y_in;
   logic signed [POS_Z_BITS-1:0]  pos_z_ff;

   // Stage 1: sine and cosine, radius = cos(B phi) + 2
   always_comb begin
      trig_a   = fold(cord_a);
      trig_b   = fold(cord_b);
      cos_a_in = $signed(trig_a[TRIG_BITS-1:0]);
      sin_a_in = $signed(trig_a[2*TRIG_BITS-1:TRIG_BITS]);
      sin_b_in = $signed(trig_b[2*TRIG_BITS-1:TRIG_BITS]);
      rad_in   = RAD_BITS'($signed(trig_b[TRIG_BITS-1:0])) + 17'sd32768;
   end

   // Stage 2: radius times cos and sin
   always_comb begin
      mul_x_in = MUL_BITS'(rad_ff) * MUL_BITS'(cos_a_ff);
      mul_y_in = MUL_BITS'(rad_ff) * MUL_BITS'(sin_a_ff);
   end

   // Stage 3: final rounding
   always_comb begin
      pos_x_in = scale(mul_x_ff);
      pos_y_in = scale(mul_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (en) begin
         trig_valid_ff <= valid_i;
         mul_valid_ff  <= trig_valid_ff;
         out_valid_ff  <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_a_ff <= cos_a_in;
         sin_a_ff <= sin_a_in;
         sin_b_ff <= sin_b_in;
         rad_ff   <= rad_in;
         mul_x_ff <= mul_x_in;
         mul_y_ff <= mul_y_in;
         mul_z_ff <= sin_b_ff;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= mul_z_ff;
      end
   end

   assign valid_o = out_valid_ff;
   assign pos_x   = pos_x_ff;
   assign pos_y   = pos_y_ff;
   assign pos_z   = pos_z_ff;

endmodule

// File: src/torus_knot_trajectory.sv
// Torus knot trajectory generator: top level with two CORDIC cell chains
// Pipeline: two phase stages, one cell per CORDIC stage, three output stages.
// Throughput: one request per cycle; the whole pipeline holds while a result
//   waits in the output register and is not taken.
// Reset: synchronous, clears all valid flags and loads A = 3.0, B = 7.0.
module torus_knot_trajectory (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: [15:0] phase_sample
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [tkt_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   // rsp_tdata: [16:0] pos_x, [33:17] pos_y, [49:34] pos_z, [55:50] zero
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [tkt_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // Register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tkt_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [tkt_pkg::FACTOR_BITS-1:0]         csr_data
);
   import tkt_pkg::*;
   `include "torus_knot_trajectory_defines.svh"

   logic                           en;
   logic                           req_accept;
   logic [SAMPLE_BITS-1:0]         sample;
   logic [FACTOR_BITS-1:0]         factor_a_ff;
   logic [FACTOR_BITS-1:0]         factor_b_ff;
   logic                           valid_a [0:CORDIC_STAGES];
   logic                           valid_b [0:CORDIC_STAGES];
   cordic_data_type                data_a  [0:CORDIC_STAGES];
   cordic_data_type                data_b  [0:CORDIC_STAGES];
   logic                           out_valid;
   logic signed [POS_XY_BITS-1:0]  pos_x;
   logic signed [POS_XY_BITS-1:0]  pos_y;
   logic signed [POS_Z_BITS-1:0]   pos_z;

   // Pipeline moves whenever the output register is free or being emptied
   assign en         = !out_valid || rsp_tready;
   assign req_tready = en;
   assign req_accept = req_tvalid && en;
   assign sample     = SAMPLE_BITS'(req_tdata);

   // Winding factor registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_a_ff <= FACTOR_A_RESET;
         factor_b_ff <= FACTOR_B_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FACTOR_A: factor_a_ff <= csr_data;
            CSR_FACTOR_B: factor_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Phase front ends for A and B
   tkt_phase u_phase_a (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (req_accept),
      .sample  (sample),
      .factor  (factor_a_ff),
      .valid_o (valid_a[0]),
      .data_o  (data_a[0])
   );

   tkt_phase u_phase_b (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (req_accept),
      .sample  (sample),
      .factor  (factor_b_ff),
      .valid_o (valid_b[0]),
      .data_o  (data_b[0])
   );

   // Two rows of CORDIC cells
   generate
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cells
         tkt_cell u_cell_a (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .stage_idx (IDX_BITS'(i)),
            .valid_i   (valid_a[i]),
            .data_i    (data_a[i]),
            .valid_o   (valid_a[i+1]),
            .data_o    (data_a[i+1])
         );
         tkt_cell u_cell_b (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .stage_idx (IDX_BITS'(i)),
            .valid_i   (valid_b[i]),
            .data_i    (data_b[i]),
            .valid_o   (valid_b[i+1]),
            .data_o    (data_b[i+1])
         );
      end
   endgenerate

   // Fold-back, scaling and output register
   tkt_post u_post (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (valid_a[CORDIC_STAGES]),
      .cord_a  (data_a[CORDIC_STAGES]),
      .cord_b  (data_b[CORDIC_STAGES]),
      .valid_o (out_valid),
      .pos_x   (pos_x),
      .pos_y   (pos_y),
      .pos_z   (pos_z)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {{(RSP_DATA_BITS-POS_Z_BITS-2*POS_XY_BITS){1'b0}}, pos_z, pos_y, pos_x};

   // Checks
   `TKT_ASSERT_NOW(a_chain_entry_match, clock, reset, 1'b1, valid_a[0] == valid_b[0], "A and B chain entries out of step")
   `TKT_ASSERT_NOW(a_chain_exit_match, clock, reset, 1'b1, valid_a[CORDIC_STAGES] == valid_b[CORDIC_STAGES], "A and B chain exits out of step")
   `TKT_ASSERT_NOW(a_z_range, clock, reset, out_valid, (pos_z <= 16'sd16384) && (pos_z >= -16'sd16384), "pos_z out of range")
   `TKT_ASSERT_NOW(a_x_range, clock, reset, out_valid, (pos_x <= 17'sd49152) && (pos_x >= -17'sd49152), "pos_x out of range")
   `TKT_ASSERT_NEXT(a_csr_hold_idle, clock, reset, csr_valid && (csr_index != CSR_FACTOR_A) && (csr_index != CSR_FACTOR_B), $stable(factor_a_ff) && $stable(factor_b_ff), "write to unknown index changed a factor")

endmodule
